/* src/sjis_text_console_cursor_macros.svh */
// ----------------------------------------------------------------------------
// sjis_text_console_cursor_macros.svh
// Assertion macros for the Shift-JIS text console cursor. The checks compile
// away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SJIS_TEXT_CONSOLE_CURSOR_MACROS_SVH
`define SJIS_TEXT_CONSOLE_CURSOR_MACROS_SVH

`ifndef SYNTHESIS
`define SJTC_ASSERT(lbl, clk_sig, rst_sig, prop, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) (prop)) else $error(msg);
`define SJTC_ASSERT_NEXT(lbl, clk_sig, rst_sig, ante, cons, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SJTC_ASSERT(lbl, clk_sig, rst_sig, prop, msg)
`define SJTC_ASSERT_NEXT(lbl, clk_sig, rst_sig, ante, cons, msg)
`endif

`endif

/* src/sjtc_pkg.sv */
// ----------------------------------------------------------------------------
// sjtc_pkg
// Codes, microcode word layout and control store of the Shift-JIS text
// console cursor.
// ----------------------------------------------------------------------------
package sjtc_pkg;

  localparam int ColW  = 7;
  localparam int RowW  = 6;
  localparam int CodeW = 14;
  localparam int PcW   = 5;

  // Configuration register indexes.
  localparam logic REG_SCREEN_COLUMNS = 1'b0;
  localparam logic REG_SCREEN_ROWS    = 1'b1;

  localparam logic [7:0] ScreenColumnsReset = 8'd106;
  localparam logic [6:0] ScreenRowsReset    = 7'd30;

  // Result kinds.
  localparam logic [1:0] KIND_CURSOR = 2'd0;
  localparam logic [1:0] KIND_HALF   = 2'd1;
  localparam logic [1:0] KIND_FULL   = 2'd2;
  localparam logic [1:0] KIND_SCROLL = 2'd3;

  // Control bytes.
  localparam logic [7:0] CHR_NUL   = 8'h00;
  localparam logic [7:0] CHR_BS    = 8'h08;
  localparam logic [7:0] CHR_TAB   = 8'h09;
  localparam logic [7:0] CHR_LF    = 8'h0a;
  localparam logic [7:0] CHR_SPACE = 8'h20;

  // Emit modes.
  localparam logic [1:0] EM_NONE   = 2'd0;
  localparam logic [1:0] EM_ALWAYS = 2'd1;
  localparam logic [1:0] EM_FLAG   = 2'd2;

  // Cursor operations.
  localparam logic [2:0] OP_NONE    = 3'd0;
  localparam logic [2:0] OP_RIGHT   = 3'd1;
  localparam logic [2:0] OP_DOWN_F  = 3'd2;
  localparam logic [2:0] OP_LEFT    = 3'd3;
  localparam logic [2:0] OP_NEWLINE = 3'd4;
  localparam logic [2:0] OP_FIT     = 3'd5;

  // Branch conditions: taken goes to target, not taken to the next step.
  localparam logic [1:0] BR_NEXT      = 2'd0;
  localparam logic [1:0] BR_ALWAYS    = 2'd1;
  localparam logic [1:0] BR_UNALIGNED = 2'd2;
  localparam logic [1:0] BR_END       = 2'd3;

  // Program entry points.
  localparam logic [PcW-1:0] UA_PRINT = 5'd0;
  localparam logic [PcW-1:0] UA_TAB   = 5'd3;
  localparam logic [PcW-1:0] UA_FINAL = 5'd6;
  localparam logic [PcW-1:0] UA_BS    = 5'd7;
  localparam logic [PcW-1:0] UA_NL    = 5'd8;
  localparam logic [PcW-1:0] UA_FULL  = 5'd10;
  localparam logic [PcW-1:0] UA_LAST  = 5'd18;

  typedef struct packed {
    logic [1:0]     emit;
    logic [1:0]     kind;
    logic           last;
    logic [2:0]     op;
    logic [1:0]     br;
    logic [PcW-1:0] target;
  } uc_word_t;

  function automatic uc_word_t uc(input logic [1:0] emit, input logic [1:0] kind,
                                  input logic last, input logic [2:0] op,
                                  input logic [1:0] br, input logic [PcW-1:0] target);
    uc_word_t w;
    w.emit   = emit;
    w.kind   = kind;
    w.last   = last;
    w.op     = op;
    w.br     = br;
    w.target = target;
    return w;
  endfunction

  function automatic uc_word_t uc_rom(input logic [PcW-1:0] pc);
    uc_word_t w;
    case (pc)
      // Printable byte: draw, step right, scroll if the wrap ran off the bottom.
      5'd0:    w = uc(EM_ALWAYS, KIND_HALF,   1'b0, OP_RIGHT,   BR_NEXT,      UA_FINAL);
      5'd1:    w = uc(EM_NONE,   KIND_CURSOR, 1'b0, OP_DOWN_F,  BR_NEXT,      UA_FINAL);
      5'd2:    w = uc(EM_FLAG,   KIND_SCROLL, 1'b0, OP_NONE,    BR_ALWAYS,    UA_FINAL);
      // Tab: spaces until the column is a multiple of four.
      5'd3:    w = uc(EM_ALWAYS, KIND_HALF,   1'b0, OP_RIGHT,   BR_NEXT,      UA_FINAL);
      5'd4:    w = uc(EM_NONE,   KIND_CURSOR, 1'b0, OP_DOWN_F,  BR_NEXT,      UA_FINAL);
      5'd5:    w = uc(EM_FLAG,   KIND_SCROLL, 1'b0, OP_NONE,    BR_UNALIGNED, UA_TAB);
      5'd6:    w = uc(EM_ALWAYS, KIND_CURSOR, 1'b1, OP_NONE,    BR_END,       UA_FINAL);
      5'd7:    w = uc(EM_NONE,   KIND_CURSOR, 1'b0, OP_LEFT,    BR_ALWAYS,    UA_FINAL);
      5'd8:    w = uc(EM_NONE,   KIND_CURSOR, 1'b0, OP_NEWLINE, BR_NEXT,      UA_FINAL);
      5'd9:    w = uc(EM_FLAG,   KIND_SCROLL, 1'b0, OP_NONE,    BR_ALWAYS,    UA_FINAL);
      // Full-width glyph: newline first if two cells do not fit, then two steps.
      5'd10:   w = uc(EM_NONE,   KIND_CURSOR, 1'b0, OP_FIT,     BR_NEXT,      UA_FINAL);
      5'd11:   w = uc(EM_NONE,   KIND_CURSOR, 1'b0, OP_DOWN_F,  BR_NEXT,      UA_FINAL);
      5'd12:   w = uc(EM_FLAG,   KIND_SCROLL, 1'b0, OP_NONE,    BR_NEXT,      UA_FINAL);
      5'd13:   w = uc(EM_ALWAYS, KIND_FULL,   1'b0, OP_RIGHT,   BR_NEXT,      UA_FINAL);
      5'd14:   w = uc(EM_NONE,   KIND_CURSOR, 1'b0, OP_DOWN_F,  BR_NEXT,      UA_FINAL);
      5'd15:   w = uc(EM_FLAG,   KIND_SCROLL, 1'b0, OP_NONE,    BR_NEXT,      UA_FINAL);
      5'd16:   w = uc(EM_NONE,   KIND_CURSOR, 1'b0, OP_RIGHT,   BR_NEXT,      UA_FINAL);
      5'd17:   w = uc(EM_NONE,   KIND_CURSOR, 1'b0, OP_DOWN_F,  BR_NEXT,      UA_FINAL);
      5'd18:   w = uc(EM_FLAG,   KIND_SCROLL, 1'b0, OP_NONE,    BR_ALWAYS,    UA_FINAL);
      default: w = uc(EM_ALWAYS, KIND_CURSOR, 1'b1, OP_NONE,    BR_END,       UA_FINAL);
    endcase
    return w;
  endfunction

endpackage

/* src/sjis_text_console_cursor.sv */
// ----------------------------------------------------------------------------
// sjis_text_console_cursor
// One beat is worked on at a time: a beat that starts a microcode program
// is not followed by another until the program ends, and an output stall
// holds any step that emits. Set-cursor runs only the final step.
// Synchronous reset clears the cursor, pending lead and sequencer, and loads
// 106 columns by 30 rows.
// ----------------------------------------------------------------------------
`include "sjis_text_console_cursor_macros.svh"

module sjis_text_console_cursor #(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 64
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration write port.
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  // Input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // data_byte[7:0], set_col[15:8], set_row[23:16]
  input  logic [0:0]  s_tuser,   // func[0]
  // Result stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // draw_col[6:0], draw_row[12:7], glyph_code[26:13],
                                 // cursor_col[33:27], cursor_row[39:34]
  output logic [1:0]  m_tuser,   // kind[1:0]
  output logic        m_tlast
);
  import sjtc_pkg::*;

  localparam logic [7:0] MaxColsC = 8'(MAX_COLS);
  localparam logic [6:0] MaxRowsC = 7'(MAX_ROWS);

  logic [7:0]       screen_columns;
  logic [6:0]       screen_rows;
  logic [7:0]       lead_byte;
  logic             lead_pending;
  logic [ColW-1:0]  col;
  logic [RowW-1:0]  row;
  logic [CodeW-1:0] code;
  logic             flag;
  logic             busy;
  logic [PcW-1:0]   pc;

  logic [7:0]       cols_eff;
  logic [6:0]       rows_eff;
  logic [7:0]       cols_m1;
  logic [6:0]       rows_m1;
  logic [ColW-1:0]  col_cl;
  logic [RowW-1:0]  row_cl;
  logic [7:0]       b;
  logic [7:0]       set_c;
  logic [7:0]       set_r;
  logic             is_lead;
  logic             is_trail;
  logic [7:0]       lead_off;
  logic [6:0]       ku_m1;
  logic [6:0]       ten;
  logic [CodeW-1:0] kuten;
  logic             accept;
  logic [PcW-1:0]   single_pc;
  logic [7:0]       single_code;
  logic             single_busy;

  uc_word_t         w;
  logic             emit_need;
  logic             step_go;
  logic [7:0]       col_inc;
  logic             col_wrap;
  logic [6:0]       row_inc;
  logic             row_over;
  logic             glyph;
  logic             cursor_ok;
  logic             last_beat;

  assign cols_eff = (screen_columns < 8'd2) ? 8'd2 :
                    ((screen_columns > MaxColsC) ? MaxColsC : screen_columns);
  assign rows_eff = (screen_rows < 7'd1) ? 7'd1 :
                    ((screen_rows > MaxRowsC) ? MaxRowsC : screen_rows);
  assign cols_m1  = cols_eff - 8'd1;
  assign rows_m1  = rows_eff - 7'd1;
  assign col_cl   = ({1'b0, col} >= cols_eff) ? cols_m1[ColW-1:0] : col;
  assign row_cl   = ({1'b0, row} >= rows_eff) ? rows_m1[RowW-1:0] : row;

  assign b        = s_tdata[7:0];
  assign set_c    = s_tdata[15:8];
  assign set_r    = s_tdata[23:16];
  assign is_lead  = (b >= 8'h81 && b <= 8'h9f) || (b >= 8'he0 && b <= 8'hef);
  assign is_trail = (b >= 8'h40 && b <= 8'h7e) || (b >= 8'h80 && b <= 8'hfc);

  // Row index of the pair minus one; the upper trail range selects the even row.
  always_comb begin
    if (lead_byte <= 8'h9f) begin
      lead_off = lead_byte - 8'h81;
      ku_m1    = {lead_off[5:0], 1'b0};
    end else begin
      lead_off = lead_byte - 8'he0;
      ku_m1    = {lead_off[5:0], 1'b0} + 7'd62;
    end
    if (b >= 8'h9f) begin
      ku_m1 = ku_m1 + 7'd1;
    end
    if (b <= 8'h7e) begin
      ten = 7'(b - 8'h3f);
    end else if (b <= 8'h9e) begin
      ten = 7'(b - 8'h40);
    end else begin
      ten = 7'(b - 8'h9e);
    end
  end
  assign kuten = CodeW'(ku_m1) * 14'd94 + CodeW'(ten);

  // Dispatch for a byte handled on its own.
  always_comb begin
    single_busy = 1'b1;
    single_code = b;
    case (b)
      CHR_NUL: begin
        single_busy = 1'b0;
        single_pc   = UA_FINAL;
      end
      CHR_LF:  single_pc = UA_NL;
      CHR_BS:  single_pc = UA_BS;
      CHR_TAB: begin
        single_pc   = UA_TAB;
        single_code = CHR_SPACE;
      end
      default: single_pc = (b >= CHR_SPACE) ? UA_PRINT : UA_FINAL;
    endcase
  end

  assign s_tready  = !busy;
  assign accept    = s_tvalid && s_tready;

  assign w         = uc_rom(pc);
  assign emit_need = (w.emit == EM_ALWAYS) || (w.emit == EM_FLAG && flag);
  assign step_go   = busy && (!emit_need || !m_tvalid || m_tready);

  assign col_inc   = {1'b0, col} + 8'd1;
  assign col_wrap  = col_inc >= cols_eff;
  assign row_inc   = {1'b0, row} + 7'd1;
  assign row_over  = row_inc >= rows_eff;
  assign glyph     = (w.kind == KIND_HALF) || (w.kind == KIND_FULL);

  assign cursor_ok = ({1'b0, col} < cols_eff) && ({1'b0, row} < rows_eff);
  assign last_beat = step_go && emit_need && w.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_columns <= ScreenColumnsReset;
      screen_rows    <= ScreenRowsReset;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCREEN_COLUMNS: screen_columns <= cfg_data;
        REG_SCREEN_ROWS:    screen_rows    <= cfg_data[6:0];
        default:            screen_rows    <= screen_rows;
      endcase
    end
  end

  // Sequencer and cursor datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      lead_byte    <= 8'd0;
      lead_pending <= 1'b0;
      col          <= '0;
      row          <= '0;
      flag         <= 1'b0;
      busy         <= 1'b0;
      pc           <= UA_FINAL;
    end else if (accept) begin
      flag <= 1'b0;
      if (s_tuser[0]) begin
        col  <= (set_c >= cols_eff) ? cols_m1[ColW-1:0] : set_c[ColW-1:0];
        row  <= (set_r >= {1'b0, rows_eff}) ? rows_m1[RowW-1:0] : set_r[RowW-1:0];
        pc   <= UA_FINAL;
        busy <= 1'b1;
      end else begin
        col <= col_cl;
        row <= row_cl;
        if (lead_pending) begin
          lead_pending <= 1'b0;
          if (is_trail) begin
            code <= kuten;
            pc   <= UA_FULL;
            busy <= 1'b1;
          end else begin
            code <= CodeW'(single_code);
            pc   <= single_pc;
            busy <= single_busy;
          end
        end else if (is_lead) begin
          lead_byte    <= b;
          lead_pending <= 1'b1;
        end else begin
          code <= CodeW'(single_code);
          pc   <= single_pc;
          busy <= single_busy;
        end
      end
    end else if (step_go) begin
      case (w.op)
        OP_RIGHT: begin
          col  <= col_wrap ? '0 : col_inc[ColW-1:0];
          flag <= col_wrap;
        end
        OP_DOWN_F: begin
          if (flag) begin
            row  <= row_over ? rows_m1[RowW-1:0] : row_inc[RowW-1:0];
            flag <= row_over;
          end
        end
        OP_NEWLINE: begin
          col  <= '0;
          row  <= row_over ? rows_m1[RowW-1:0] : row_inc[RowW-1:0];
          flag <= row_over;
        end
        OP_LEFT: begin
          if (col == '0) begin
            col <= cols_m1[ColW-1:0];
            if (row != '0) begin
              row <= row - RowW'(1);
            end
          end else begin
            col <= col - ColW'(1);
          end
        end
        OP_FIT: begin
          if ({1'b0, col} + 8'd2 > cols_eff) begin
            col  <= '0;
            flag <= 1'b1;
          end else begin
            flag <= 1'b0;
          end
        end
        default: flag <= flag;
      endcase
      case (w.br)
        BR_ALWAYS:    pc <= w.target;
        BR_UNALIGNED: pc <= (col[1:0] != 2'd0) ? w.target : pc + PcW'(1);
        BR_END:       busy <= 1'b0;
        default:      pc <= pc + PcW'(1);
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step_go && emit_need) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_go && emit_need) begin
      m_tuser        <= w.kind;
      m_tlast        <= w.last;
      m_tdata[6:0]   <= glyph ? col : '0;
      m_tdata[12:7]  <= glyph ? row : '0;
      m_tdata[26:13] <= glyph ? code : '0;
      m_tdata[33:27] <= col;
      m_tdata[39:34] <= row;
    end
  end

  `SJTC_ASSERT(a_cursor_on_screen, clk, rst, !busy || cursor_ok, "cursor off screen while busy")
  `SJTC_ASSERT(a_pc_in_program, clk, rst, !busy || (pc <= UA_LAST), "step counter past the program")
  `SJTC_ASSERT_NEXT(a_last_ends_program, clk, rst, last_beat, !busy, "still busy after final beat")

endmodule

/* dv/sjis_text_console_cursor_test.sv */
// ----------------------------------------------------------------------------
// sjis_text_console_cursor_test
// Self-checking testbench for the Shift-JIS text console cursor. A predictor
// tracks the cursor, the pending lead byte and the screen size, and queues
// the expected draw, scroll and cursor commands for each accepted input
// beat that yields any. The checker compares each result beat field by field against the
// oldest queued command, under several screen sizes and idle/stall mixes.
// ----------------------------------------------------------------------------
module sjis_text_console_cursor_test;
  import sjtc_pkg::*;

  localparam int CLK_PERIOD     = 4;
  localparam int TIMEOUT_CYCLES = 250000;
  localparam int SETTLE_CYCLES  = 30;
  localparam int MAX_CMDS       = 8;
  localparam int SCREEN_MAX_COLS = 128;
  localparam int SCREEN_MAX_ROWS = 64;
  localparam logic FUNC_BYTE   = 1'b0;
  localparam logic FUNC_CURSOR = 1'b1;

  typedef struct packed {
    logic [1:0]  kind;
    logic [6:0]  draw_col;
    logic [5:0]  draw_row;
    logic [13:0] glyph;
    logic [6:0]  cur_col;
    logic [5:0]  cur_row;
    logic        last_flag;
  } console_cmd_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic        cfg_index;
  logic [7:0]  cfg_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;
  logic [0:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  sjis_text_console_cursor u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // Console state as the predictor sees it.
  logic [7:0] scr_cols;
  logic [6:0] scr_rows;
  int         lead_code;
  bit         lead_valid;
  int         cur_col;
  int         cur_row;
  int         cols_eff;
  int         rows_eff;
  int         step_cmds;

  console_cmd_t expected_cmds[$];

  int  err_count;
  int  beats_sent;
  int  checked_cmds;
  int  screen_settings;
  int  send_idle_pct;
  int  recv_stall_pct;
  int  hold_len;
  logic rx_hold;
  event hold_go;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("Timeout with %0d commands still expected.", expected_cmds.size());
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int clamp_int(input int v, input int lo, input int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic int screen_cols_now();
    return clamp_int(int'(scr_cols), 2, SCREEN_MAX_COLS);
  endfunction

  function automatic int screen_rows_now();
    return clamp_int(int'(scr_rows), 1, SCREEN_MAX_ROWS);
  endfunction

  function automatic void queue_cmd(input logic [1:0] kind, input int dcol, input int drow,
                                    input int code);
    console_cmd_t c;
    if (step_cmds >= MAX_CMDS) return;
    c.kind      = kind;
    c.draw_col  = dcol[6:0];
    c.draw_row  = drow[5:0];
    c.glyph     = code[13:0];
    c.cur_col   = cur_col[6:0];
    c.cur_row   = cur_row[5:0];
    c.last_flag = 1'b0;
    expected_cmds.push_back(c);
    step_cmds++;
  endfunction

  function automatic void cursor_down();
    cur_row++;
    if (cur_row >= rows_eff) begin
      cur_row = rows_eff - 1;
      queue_cmd(KIND_SCROLL, 0, 0, 0);
    end
  endfunction

  function automatic void cursor_right();
    cur_col++;
    if (cur_col >= cols_eff) begin
      cur_col = 0;
      cursor_down();
    end
  endfunction

  // Backspace at column zero wraps to the end of the previous row (row zero stays).
  function automatic void cursor_left();
    if (cur_col == 0) begin
      cur_col = cols_eff - 1;
      if (cur_row > 0) cur_row--;
    end else begin
      cur_col--;
    end
  endfunction

  function automatic void draw_half(input int code);
    queue_cmd(KIND_HALF, cur_col, cur_row, code);
    cursor_right();
  endfunction

  function automatic void handle_single(input logic [7:0] b);
    int g;
    if (b == CHR_LF) begin
      cur_col = 0;
      cursor_down();
    end else if (b == CHR_TAB) begin
      draw_half(CHR_SPACE);
      for (g = 0; g < 4 && (cur_col % 4) != 0; g++) draw_half(CHR_SPACE);
    end else if (b == CHR_BS) begin
      cursor_left();
    end else if (b >= CHR_SPACE) begin
      draw_half(b);
    end
  endfunction

  function automatic bit is_lead_byte(input logic [7:0] b);
    return (b >= 8'h81 && b <= 8'h9f) || (b >= 8'he0 && b <= 8'hef);
  endfunction

  function automatic void predict_console(input logic fn, input logic [7:0] b,
                                          input logic [7:0] sc, input logic [7:0] sr);
    int ku;
    int ten;
    step_cmds = 0;
    cols_eff  = screen_cols_now();
    rows_eff  = screen_rows_now();
    if (cur_col >= cols_eff) cur_col = cols_eff - 1;
    if (cur_row >= rows_eff) cur_row = rows_eff - 1;

    if (fn == FUNC_CURSOR) begin
      cur_col = (sc >= cols_eff) ? cols_eff - 1 : int'(sc);
      cur_row = (sr >= rows_eff) ? rows_eff - 1 : int'(sr);
    end else if (lead_valid) begin
      lead_valid = 1'b0;
      ku  = (lead_code <= 'h9f) ? (lead_code - 'h81) * 2 + 1 : (lead_code - 'he0) * 2 + 63;
      ten = 0;
      if (b >= 8'h40 && b <= 8'h7e) begin
        ten = int'(b) - 'h40 + 1;
      end else if (b >= 8'h80 && b <= 8'h9e) begin
        ten = int'(b) - 'h80 + 64;
      end else if (b >= 8'h9f && b <= 8'hfc) begin
        ku++;
        ten = int'(b) - 'h9f + 1;
      end else if (b == CHR_NUL) begin
        return;
      end else begin
        // A bad trail drops the lead and is taken as a byte of its own.
        handle_single(b);
      end
      if (ten != 0) begin
        if (cur_col + 2 > cols_eff) begin
          cur_col = 0;
          cursor_down();
        end
        queue_cmd(KIND_FULL, cur_col, cur_row, (ku - 1) * 94 + ten);
        cursor_right();
        cursor_right();
      end
    end else begin
      if (b == CHR_NUL) return;
      if (is_lead_byte(b)) begin
        lead_code  = int'(b);
        lead_valid = 1'b1;
        return;
      end
      handle_single(b);
    end

    queue_cmd(KIND_CURSOR, 0, 0, 0);
    expected_cmds[expected_cmds.size() - 1].last_flag = 1'b1;
  endfunction

  // ------------------------------------------------------------------ checker

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d, expected %0d (command %0d)", what, got, want,
             checked_cmds);
    err_count++;
  endtask

  task automatic check_cmd();
    console_cmd_t want;
    if (expected_cmds.size() == 0) begin
      report_mismatch("unexpected command, kind", m_tuser, 0);
      return;
    end
    want = expected_cmds.pop_front();
    checked_cmds++;
    if (m_tuser !== want.kind) report_mismatch("kind", m_tuser, want.kind);
    if (m_tdata[6:0] !== want.draw_col) report_mismatch("draw_col", m_tdata[6:0], want.draw_col);
    if (m_tdata[12:7] !== want.draw_row)
      report_mismatch("draw_row", m_tdata[12:7], want.draw_row);
    if (m_tdata[26:13] !== want.glyph) report_mismatch("glyph_code", m_tdata[26:13], want.glyph);
    if (m_tdata[33:27] !== want.cur_col)
      report_mismatch("cursor_col", m_tdata[33:27], want.cur_col);
    if (m_tdata[39:34] !== want.cur_row)
      report_mismatch("cursor_row", m_tdata[39:34], want.cur_row);
    if (m_tlast !== want.last_flag) report_mismatch("last", m_tlast, want.last_flag);
  endtask

  // The check uses the ready value from before this edge, then picks the next one.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) check_cmd();
      m_tready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Long receiver hold-off, counted here so the sender keeps running meanwhile.
  initial begin
    rx_hold <= 1'b0;
    forever begin
      @(hold_go);
      rx_hold <= 1'b1;
      repeat (hold_len) @(posedge clk);
      rx_hold <= 1'b0;
    end
  end

  // ------------------------------------------------------------------- driver

  task automatic send_beat(input logic fn, input logic [7:0] b, input logic [7:0] sc,
                           input logic [7:0] sr);
    int gap;
    gap = 0;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct && gap < 12) gap++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= fn;
    s_tdata  <= {sr, sc, b};
    do @(posedge clk); while (!s_tready);
    predict_console(fn, b, sc, sr);
    beats_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_beat(FUNC_BYTE, b, 8'($urandom_range(255)), 8'($urandom_range(255)));
  endtask

  task automatic send_cursor(input logic [7:0] sc, input logic [7:0] sr);
    send_beat(FUNC_CURSOR, 8'($urandom_range(255)), sc, sr);
  endtask

  // Stops offering beats and waits until every expected command has come out.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_cmds.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_screen(input logic [7:0] cols, input logic [7:0] rows);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_SCREEN_COLUMNS;
    cfg_data  <= cols;
    @(posedge clk);
    cfg_index <= REG_SCREEN_ROWS;
    cfg_data  <= rows;
    @(posedge clk);
    cfg_we   <= 1'b0;
    scr_cols = cols;
    scr_rows = rows[6:0];
    screen_settings++;
    @(posedge clk);
  endtask

  function automatic logic [7:0] pick_lead();
    return $urandom_range(1) ? 8'($urandom_range(8'h81, 8'h9f))
                             : 8'($urandom_range(8'he0, 8'hef));
  endfunction

  function automatic logic [7:0] pick_trail();
    logic [7:0] t;
    t = 8'($urandom_range(8'h40, 8'hfc));
    if (t == 8'h7f) t = 8'h80;
    return t;
  endfunction

  function automatic logic [7:0] pick_bad_trail();
    case ($urandom_range(4))
      0:       return CHR_NUL;
      1:       return 8'($urandom_range(8'h01, 8'h3f));
      2:       return 8'h7f;
      3:       return CHR_LF;
      default: return 8'($urandom_range(8'hfd, 8'hff));
    endcase
  endfunction

  function automatic logic [7:0] pick_printable();
    case ($urandom_range(2))
      0:       return 8'($urandom_range(8'ha0, 8'hdf));
      1:       return 8'($urandom_range(8'hf0, 8'hff));
      default: return 8'($urandom_range(8'h20, 8'h7e));
    endcase
  endfunction

  // Mostly well-formed text with random content; the rest is noise.
  task automatic random_text(input int n);
    int pick;
    logic [7:0] sc;
    logic [7:0] sr;
    repeat (n) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        send_byte(pick_printable());
      end else if (pick < 60) begin
        send_byte(pick_lead());
        send_byte(pick_trail());
      end else if (pick < 72) begin
        case ($urandom_range(2))
          0:       send_byte(CHR_LF);
          1:       send_byte(CHR_TAB);
          default: send_byte(CHR_BS);
        endcase
      end else if (pick < 82) begin
        sc = $urandom_range(1) ? 8'($urandom_range(255)) : 8'($urandom_range(screen_cols_now() - 1));
        sr = $urandom_range(1) ? 8'($urandom_range(255)) : 8'($urandom_range(screen_rows_now() - 1));
        send_cursor(sc, sr);
      end else if (pick < 92) begin
        send_byte(8'($urandom_range(255)));
      end else begin
        send_byte(pick_lead());
        send_byte(pick_bad_trail());
      end
    end
  endtask

  // -------------------------------------------------------------------- tests

  // Default 106 x 30 screen: controls, glyph extremes, wraps and bad trails.
  task automatic test_directed();
    send_byte(8'h41);
    send_byte(8'hff);
    send_byte(8'h01);
    send_byte(CHR_NUL);
    send_byte(CHR_LF);
    send_byte(CHR_TAB);
    send_byte(8'h78);
    send_byte(CHR_TAB);
    send_byte(CHR_BS);
    send_cursor(8'd0, 8'd3);
    send_byte(CHR_BS);
    send_cursor(8'd0, 8'd0);
    send_byte(CHR_BS);
    send_byte(8'h81); send_byte(8'h40);
    send_byte(8'h9f); send_byte(8'h7e);
    send_byte(8'he0); send_byte(8'h80);
    send_byte(8'hef); send_byte(8'hfc);
    send_byte(8'h88); send_byte(8'h9f);
    send_byte(8'h81); send_byte(8'h30);
    send_byte(8'h81); send_byte(CHR_NUL);
    // A set-cursor beat leaves the pending lead alone.
    send_byte(8'h82); send_cursor(8'd10, 8'd10); send_byte(8'h9e);
    send_byte(8'he5); send_byte(CHR_LF);
    send_byte(8'h90); send_byte(8'hfd);
    send_cursor(8'hff, 8'hff);
    send_byte(8'h41);
    send_cursor(8'd105, 8'd29);
    send_byte(8'h83); send_byte(8'h50);
    send_cursor(8'd104, 8'd5);
    send_byte(8'h84); send_byte(8'h60);
    send_cursor(8'hff, 8'd0);
    send_byte(CHR_TAB);
  endtask

  // Screen sizes including both saturation ends and a cursor left off-screen.
  task automatic test_screen_sweep();
    logic [7:0] cols_list[8] = '{8'd128, 8'd2, 8'd0, 8'd255, 8'd1, 8'd5, 8'd9, 8'd40};
    logic [7:0] rows_list[8] = '{8'd64, 8'd1, 8'd0, 8'hff, 8'h80, 8'd3, 8'd2, 8'd12};
    int i;
    for (i = 0; i < 8; i++) begin
      write_screen(cols_list[i], rows_list[i]);
      if (i == 0) send_cursor(8'd127, 8'd63);
      random_text(10);
    end
  endtask

  task automatic test_idle_phases();
    int send_mix[4] = '{0, 51, 0, 9};
    int recv_mix[4] = '{0, 0, 51, 9};
    int p;
    for (p = 0; p < 4; p++) begin
      if (p == 3) write_screen(ScreenColumnsReset, 8'(ScreenRowsReset));
      else write_screen(8'($urandom_range(2, 24)), 8'($urandom_range(1, 6)));
      send_idle_pct  = send_mix[p];
      recv_stall_pct = recv_mix[p];
      random_text(30);
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  // The receiver stops for a long stretch while beats keep coming, then the
  // sender waits for the block to drain completely.
  task automatic test_backpressure();
    write_screen(8'd20, 8'd4);
    hold_len = 300;
    -> hold_go;
    random_text(25);
    wait_idle();
    recv_stall_pct = 30;
    random_text(10);
    recv_stall_pct = 0;
  endtask

  initial begin
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_index <= REG_SCREEN_COLUMNS;
    cfg_data  <= 8'd0;
    s_tvalid  <= 1'b0;
    s_tdata   <= 24'd0;
    s_tuser   <= 1'b0;
    scr_cols        = ScreenColumnsReset;
    scr_rows        = ScreenRowsReset;
    lead_code       = 0;
    lead_valid      = 1'b0;
    cur_col         = 0;
    cur_row         = 0;
    err_count       = 0;
    beats_sent      = 0;
    checked_cmds    = 0;
    screen_settings = 1;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    hold_len        = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_screen_sweep();
    test_idle_phases();
    test_backpressure();
    wait_idle();

    $display("Sent %0d input beats and checked %0d commands over %0d screen sizes,",
             beats_sent, checked_cmds, screen_settings);
    $display("with idle and stall mixes and a long receiver hold-off; %0d mismatches.",
             err_count);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
